FILE: sv/smadd_pkg.sv
// Shared types and constants for the sparse triplet matrix adder.
package smadd_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned DIM_W    = 7;
  localparam int unsigned TOTAL_W  = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Opcodes of an input beat.
  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE  = 2'd2;

  // Status codes on the last result of a merge.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  // One stored triplet.
  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } term_t;

  localparam int unsigned TERM_W = $bits(term_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic merge_step;
    logic emit_status;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mismatch;
    logic lists_empty;
    logic merge_done;
  } flags_t;

endpackage

FILE: sv/smadd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smadd_ram #(
  parameter int unsigned WIDTH = 44,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/smadd_ctrl.sv
// Controller state machine for the sparse triplet matrix adder.
module smadd_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [smadd_pkg::OP_W-1:0]   opcode,
  input  smadd_pkg::flags_t            flags,
  output smadd_pkg::cmd_t              cmd,
  output logic                         busy
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MERGE  = 2'd1;
  localparam logic [1:0] S_STATUS = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       merge_go;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign merge_go = accept && (opcode == smadd_pkg::OP_MERGE);

  // Commands decoded from the state and the accepted beat.
  always_comb begin
    cmd             = '0;
    cmd.load_a      = accept && (opcode == smadd_pkg::OP_LOAD_A);
    cmd.load_b      = accept && (opcode == smadd_pkg::OP_LOAD_B);
    cmd.merge_step  = (state == S_MERGE);
    cmd.emit_status = (state == S_STATUS);
    cmd.clear       = cmd.emit_status || (cmd.merge_step && flags.merge_done);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (merge_go) begin
          if (flags.mismatch || flags.lists_empty) begin
            state_next = S_STATUS;
          end else begin
            state_next = S_MERGE;
          end
        end
      end
      S_MERGE: begin
        if (flags.merge_done) begin
          state_next = S_IDLE;
        end
      end
      S_STATUS: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/smadd_dp.sv
// Datapath: term lists, counters, merge compare and add, result registers.
module smadd_dp #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  smadd_pkg::cmd_t                    cmd,
  output smadd_pkg::flags_t                  flags,
  input  logic [smadd_pkg::IDX_W-1:0]        term_row,
  input  logic [smadd_pkg::IDX_W-1:0]        term_col,
  input  logic signed [smadd_pkg::VAL_W-1:0] term_value,
  input  logic                               cfg_we,
  input  logic [smadd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smadd_pkg::DIM_W-1:0]        cfg_data,
  output logic                               result_strobe,
  output logic [smadd_pkg::IDX_W-1:0]        out_row,
  output logic [smadd_pkg::IDX_W-1:0]        out_col,
  output logic signed [smadd_pkg::VAL_W-1:0] out_value,
  output logic                               is_term,
  output logic                               last,
  output logic [smadd_pkg::TOTAL_W-1:0]      term_total,
  output logic [smadd_pkg::STATUS_W-1:0]     status
);

  localparam int unsigned CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int unsigned ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned VW     = smadd_pkg::VAL_W;

  logic [smadd_pkg::DIM_W-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [CNT_W-1:0] count_a, count_b;
  logic             overflow_seen;
  logic [CNT_W-1:0] ptr_i, ptr_j, ptr_i_next, ptr_j_next;
  logic [smadd_pkg::TOTAL_W-1:0] term_cnt;

  logic                      full_a, full_b;
  logic                      wr_a, wr_b;
  smadd_pkg::term_t          wr_term;
  logic [smadd_pkg::TERM_W-1:0] rd_a_raw, rd_b_raw;
  smadd_pkg::term_t          term_a, term_b;

  logic                      a_vld, b_vld, take_a, take_b;
  logic [2*smadd_pkg::IDX_W-1:0] pos_a, pos_b;
  logic signed [VW:0]        sum_wide;
  logic signed [VW-1:0]      sum_sat;
  logic [CNT_W-1:0]          ptr_i_step, ptr_j_step;
  logic                      done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= smadd_pkg::DIM_W'(1);
      cols_a <= smadd_pkg::DIM_W'(1);
      rows_b <= smadd_pkg::DIM_W'(1);
      cols_b <= smadd_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        smadd_pkg::REG_ROWS_A: rows_a <= cfg_data;
        smadd_pkg::REG_COLS_A: cols_a <= cfg_data;
        smadd_pkg::REG_ROWS_B: rows_b <= cfg_data;
        smadd_pkg::REG_COLS_B: cols_b <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Load path: append to a list unless it is full.
  assign full_a  = (count_a >= CNT_W'(MAX_TERMS));
  assign full_b  = (count_b >= CNT_W'(MAX_TERMS));
  assign wr_a    = cmd.load_a && !full_a;
  assign wr_b    = cmd.load_b && !full_b;
  assign wr_term = '{row: term_row, col: term_col, value: term_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.clear) begin
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (wr_a) begin
        count_a <= count_a + CNT_W'(1);
      end
      if (wr_b) begin
        count_b <= count_b + CNT_W'(1);
      end
      if ((cmd.load_a && full_a) || (cmd.load_b && full_b)) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Read addresses follow the next pointers so data is ready each cycle.
  smadd_ram #(.WIDTH(smadd_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_list_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (count_a[ADDR_W-1:0]),
    .wr_data (wr_term),
    .rd_addr (ptr_i_next[ADDR_W-1:0]),
    .rd_data (rd_a_raw)
  );

  smadd_ram #(.WIDTH(smadd_pkg::TERM_W), .DEPTH(MAX_TERMS)) u_list_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (count_b[ADDR_W-1:0]),
    .wr_data (wr_term),
    .rd_addr (ptr_j_next[ADDR_W-1:0]),
    .rd_data (rd_b_raw)
  );

  assign term_a = smadd_pkg::term_t'(rd_a_raw);
  assign term_b = smadd_pkg::term_t'(rd_b_raw);

  // Merge selection: smaller row-major position first, both on a tie.
  assign a_vld = (ptr_i < count_a);
  assign b_vld = (ptr_j < count_b);
  assign pos_a = {term_a.row, term_a.col};
  assign pos_b = {term_b.row, term_b.col};

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    priority if (a_vld && b_vld) begin
      take_a = (pos_a <= pos_b);
      take_b = (pos_b <= pos_a);
    end else if (a_vld) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
    end
  end

  // Saturating 32-bit sum for matching positions.
  assign sum_wide = {term_a.value[VW-1], term_a.value} + {term_b.value[VW-1], term_b.value};
  always_comb begin
    if (sum_wide[VW] != sum_wide[VW-1]) begin
      sum_sat = sum_wide[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[VW-1:0];
    end
  end

  // Pointer advance; pointers rest at zero outside a merge.
  assign ptr_i_step = ptr_i + CNT_W'(take_a);
  assign ptr_j_step = ptr_j + CNT_W'(take_b);
  assign ptr_i_next = cmd.merge_step ? ptr_i_step : '0;
  assign ptr_j_next = cmd.merge_step ? ptr_j_step : '0;
  assign done       = (ptr_i_step >= count_a) && (ptr_j_step >= count_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_i    <= '0;
      ptr_j    <= '0;
      term_cnt <= '0;
    end else begin
      ptr_i <= ptr_i_next;
      ptr_j <= ptr_j_next;
      if (cmd.merge_step) begin
        term_cnt <= term_cnt + smadd_pkg::TOTAL_W'(1);
      end else begin
        term_cnt <= '0;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    flags             = '0;
    flags.mismatch    = (rows_a != rows_b) || (cols_a != cols_b);
    flags.lists_empty = (count_a == '0) && (count_b == '0);
    flags.merge_done  = done;
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.merge_step || cmd.emit_status;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      out_row    <= '0;
      out_col    <= '0;
      out_value  <= '0;
      is_term    <= 1'b0;
      last       <= 1'b1;
      term_total <= '0;
      if (flags.mismatch) begin
        status <= smadd_pkg::ST_MISMATCH;
      end else if (overflow_seen) begin
        status <= smadd_pkg::ST_OVERFLOW;
      end else begin
        status <= smadd_pkg::ST_OK;
      end
    end else if (cmd.merge_step) begin
      out_row    <= take_a ? term_a.row : term_b.row;
      out_col    <= take_a ? term_a.col : term_b.col;
      if (take_a && take_b) begin
        out_value <= sum_sat;
      end else begin
        out_value <= take_a ? term_a.value : term_b.value;
      end
      is_term    <= 1'b1;
      last       <= done;
      term_total <= done ? (term_cnt + smadd_pkg::TOTAL_W'(1)) : '0;
      status     <= (done && overflow_seen) ? smadd_pkg::ST_OVERFLOW : smadd_pkg::ST_OK;
    end
  end

endmodule

FILE: sv/sparse_triplet_matrix_add_top.sv
// Top level of the sparse triplet matrix adder.
// A load beat (opcode 0 or 1) does not raise busy, and the block can accept the next beat in the
// following cycle. A merge beat raises busy: after the accepting cycle the block emits one
// result per cycle, one per merged term (count_a + count_b minus matching positions), each
// appearing on the result ports in the following cycle with result_strobe high for exactly one
// cycle; a mismatch or empty merge gives a single status-only result. Busy stays high while
// the results are formed, and the next beat can be accepted at the edge that ends the cycle in
// which the last result is shown. The rate of a merge is set by the two list memories, each
// read once per cycle with registered read data.
// The receiver cannot stall: results must be captured in the cycle result_strobe is high.
// Configuration writes are always ready and should only be issued while busy is low.
module sparse_triplet_matrix_add_top #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [smadd_pkg::OP_W-1:0]         opcode,
  input  logic [smadd_pkg::IDX_W-1:0]        term_row,
  input  logic [smadd_pkg::IDX_W-1:0]        term_col,
  input  logic signed [smadd_pkg::VAL_W-1:0] term_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smadd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smadd_pkg::DIM_W-1:0]        cfg_data,
  output logic                               result_strobe,
  output logic [smadd_pkg::IDX_W-1:0]        out_row,
  output logic [smadd_pkg::IDX_W-1:0]        out_col,
  output logic signed [smadd_pkg::VAL_W-1:0] out_value,
  output logic                               is_term,
  output logic                               last,
  output logic [smadd_pkg::TOTAL_W-1:0]      term_total,
  output logic [smadd_pkg::STATUS_W-1:0]     status
);

  smadd_pkg::cmd_t   cmd;
  smadd_pkg::flags_t flags;

  assign cfg_ready = 1'b1;

  // Controller.
  smadd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .flags  (flags),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath.
  smadd_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .flags         (flags),
    .term_row      (term_row),
    .term_col      (term_col),
    .term_value    (term_value),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .is_term       (is_term),
    .last          (last),
    .term_total    (term_total),
    .status        (status)
  );

endmodule

FILE: sim/sparse_triplet_matrix_add_top_tb.sv
// Self-checking testbench for the sparse triplet matrix adder: directed plan, then random runs.
module sparse_triplet_matrix_add_top_tb;

  localparam int unsigned OP_W      = smadd_pkg::OP_W;
  localparam int unsigned IDX_W     = smadd_pkg::IDX_W;
  localparam int unsigned VAL_W     = smadd_pkg::VAL_W;
  localparam int unsigned DIM_W     = smadd_pkg::DIM_W;
  localparam int unsigned TOTAL_W   = smadd_pkg::TOTAL_W;
  localparam int unsigned STATUS_W  = smadd_pkg::STATUS_W;
  localparam int unsigned CFG_IDX_W = smadd_pkg::CFG_IDX_W;

  localparam int MAX_TERMS      = 32;
  localparam int DIM_MAX        = 64;
  localparam int RANDOM_BEATS   = 140;
  localparam int QUIET_AFTER    = 115;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT = 500;

  // Opcode that the block ignores.
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    is_term;
    logic                    last;
    logic [TOTAL_W-1:0]      total;
    logic [STATUS_W-1:0]     status;
  } result_t;

  // One command beat, with an optional hand-written expectation for merges.
  typedef struct {
    logic [OP_W-1:0]         opcode;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    bit                      no_gap;
    bit                      has_typed;
    result_t                 typed;
  } beat_t;

  // One row of the directed plan: either a command beat or a register write.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    beat_t                beat;
  } plan_row_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [OP_W-1:0]         opcode;
  logic [IDX_W-1:0]        term_row;
  logic [IDX_W-1:0]        term_col;
  logic signed [VAL_W-1:0] term_value;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [DIM_W-1:0]        cfg_data;
  logic                    result_strobe;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    is_term;
  logic                    last;
  logic [TOTAL_W-1:0]      term_total;
  logic [STATUS_W-1:0]     status;

  // Shadow copy of the block's lists, counters and dimension registers.
  smadd_pkg::term_t shadow_a [MAX_TERMS];
  smadd_pkg::term_t shadow_b [MAX_TERMS];
  int               fill_a;
  int               fill_b;
  bit               overflow_flag;
  logic [DIM_W-1:0] dim_rows_a;
  logic [DIM_W-1:0] dim_cols_a;
  logic [DIM_W-1:0] dim_rows_b;
  logic [DIM_W-1:0] dim_cols_b;

  result_t   awaited_results [$];
  beat_t     pending_beats [$];
  plan_row_t directed_plan [$];
  result_t   oldest;
  int        error_count;
  int        random_beats;
  int        idle_cycles;

  sparse_triplet_matrix_add_top #(
    .MAX_TERMS(MAX_TERMS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .term_row(term_row),
    .term_col(term_col),
    .term_value(term_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_strobe(result_strobe),
    .out_row(out_row),
    .out_col(out_col),
    .out_value(out_value),
    .is_term(is_term),
    .last(last),
    .term_total(term_total),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic result_t make_result(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                          logic signed [VAL_W-1:0] value, logic term_flag,
                                          logic last_flag, logic [TOTAL_W-1:0] total,
                                          logic [STATUS_W-1:0] code);
    result_t r;
    r.row     = row;
    r.col     = col;
    r.value   = value;
    r.is_term = term_flag;
    r.last    = last_flag;
    r.total   = total;
    r.status  = code;
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sum_saturated(logic signed [VAL_W-1:0] a,
                                                            logic signed [VAL_W-1:0] b);
    logic [VAL_W:0] wide;
    wide = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (wide[VAL_W] != wide[VAL_W-1]) return wide[VAL_W] ? VAL_MIN : VAL_MAX;
    return wide[VAL_W-1:0];
  endfunction

  // Merge the shadow lists in row-major order and queue the results it yields.
  task automatic merge_lists(beat_t b);
    result_t found [$];
    int      i;
    int      j;
    int      total;
    logic [STATUS_W-1:0] code;
    i = 0;
    j = 0;
    if (dim_rows_a != dim_rows_b || dim_cols_a != dim_cols_b) begin
      code = smadd_pkg::ST_MISMATCH;
    end else begin
      code = overflow_flag ? smadd_pkg::ST_OVERFLOW : smadd_pkg::ST_OK;
      while (i < fill_a && j < fill_b) begin
        if ({shadow_a[i].row, shadow_a[i].col} == {shadow_b[j].row, shadow_b[j].col}) begin
          found.push_back(make_result(shadow_a[i].row, shadow_a[i].col,
              sum_saturated(shadow_a[i].value, shadow_b[j].value), 1'b1, 1'b0, '0, '0));
          i++;
          j++;
        end else if ({shadow_a[i].row, shadow_a[i].col} > {shadow_b[j].row, shadow_b[j].col})
        begin
          found.push_back(make_result(shadow_b[j].row, shadow_b[j].col, shadow_b[j].value,
              1'b1, 1'b0, '0, '0));
          j++;
        end else begin
          found.push_back(make_result(shadow_a[i].row, shadow_a[i].col, shadow_a[i].value,
              1'b1, 1'b0, '0, '0));
          i++;
        end
      end
      while (i < fill_a) begin
        found.push_back(make_result(shadow_a[i].row, shadow_a[i].col, shadow_a[i].value,
            1'b1, 1'b0, '0, '0));
        i++;
      end
      while (j < fill_b) begin
        found.push_back(make_result(shadow_b[j].row, shadow_b[j].col, shadow_b[j].value,
            1'b1, 1'b0, '0, '0));
        j++;
      end
    end
    total = found.size();
    // An empty or mismatched merge still closes with one status-only beat.
    if (total == 0) found.push_back(make_result('0, '0, '0, 1'b0, 1'b0, '0, '0));
    found[found.size()-1].last   = 1'b1;
    found[found.size()-1].total  = TOTAL_W'(total);
    found[found.size()-1].status = code;
    fill_a        = 0;
    fill_b        = 0;
    overflow_flag = 1'b0;
    if (b.has_typed) begin
      awaited_results.push_back(b.typed);
    end else begin
      foreach (found[k]) awaited_results.push_back(found[k]);
    end
  endtask

  // Update the shadow state for one accepted command beat.
  task automatic predict_beat(beat_t b);
    smadd_pkg::term_t t;
    t.row   = b.row;
    t.col   = b.col;
    t.value = b.value;
    case (b.opcode)
      smadd_pkg::OP_LOAD_A: begin
        if (fill_a >= MAX_TERMS) begin
          overflow_flag = 1'b1;
        end else begin
          shadow_a[fill_a] = t;
          fill_a++;
        end
      end
      smadd_pkg::OP_LOAD_B: begin
        if (fill_b >= MAX_TERMS) begin
          overflow_flag = 1'b1;
        end else begin
          shadow_b[fill_b] = t;
          fill_b++;
        end
      end
      smadd_pkg::OP_MERGE: merge_lists(b);
      default: ;
    endcase
  endtask

  // Drive every queued command beat; start stays high across back-to-back beats.
  task automatic drive_pending();
    beat_t b;
    int    gap;
    while (pending_beats.size() != 0) begin
      b          = pending_beats.pop_front();
      start      = 1'b1;
      opcode     = b.opcode;
      term_row   = b.row;
      term_col   = b.col;
      term_value = b.value;
      do @(posedge clk); while (busy !== 1'b0);
      predict_beat(b);
      @(negedge clk);
      gap = 0;
      if (!b.no_gap && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
      if (gap != 0 || pending_beats.size() == 0) begin
        start      = 1'b0;
        opcode     = OP_W'($urandom);
        term_row   = IDX_W'($urandom);
        term_col   = IDX_W'($urandom);
        term_value = $urandom;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Wait for every awaited result, then for the block's pipeline to drain.
  task automatic settle();
    while (awaited_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] index, logic [DIM_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (index)
      smadd_pkg::REG_ROWS_A: dim_rows_a = data;
      smadd_pkg::REG_COLS_A: dim_cols_a = data;
      smadd_pkg::REG_ROWS_B: dim_rows_b = data;
      smadd_pkg::REG_COLS_B: dim_cols_b = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            logic signed [VAL_W-1:0] value, bit no_gap);
    beat_t b;
    b.opcode    = op;
    b.row       = row;
    b.col       = col;
    b.value     = value;
    b.no_gap    = no_gap;
    b.has_typed = 1'b0;
    b.typed     = '0;
    pending_beats.push_back(b);
    if (op != OP_IGNORED) random_beats++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(bit hot);
    if (hot && $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 5))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return 32'sd0;
        3: return 32'sd1;
        4: return -32'sd1;
        default: return VAL_MAX - 32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // A well-formed run: sorted lists, with shared positions unless disjoint, loads interleaved, then a merge.
  task automatic queue_merge_run(int na, int nb, bit disjoint, bit no_gap);
    smadd_pkg::term_t la [$];
    smadd_pkg::term_t lb [$];
    smadd_pkg::term_t t;
    int    pos;
    int    role;
    int    step_max;
    int    extra;
    pos      = $urandom_range(0, 63);
    step_max = disjoint ? 60 : $urandom_range(1, 300);
    while ((la.size() < na || lb.size() < nb) && pos < DIM_MAX * DIM_MAX) begin
      if (la.size() < na && lb.size() < nb)
        role = disjoint ? $urandom_range(0, 1) : $urandom_range(0, 2);
      else
        role = (la.size() < na) ? 0 : 1;
      t.row = IDX_W'(pos / DIM_MAX);
      t.col = IDX_W'(pos % DIM_MAX);
      if (role != 1) begin
        t.value = pick_value(role == 2);
        la.push_back(t);
      end
      if (role != 0) begin
        t.value = pick_value(role == 2);
        lb.push_back(t);
      end
      pos += $urandom_range(1, step_max);
    end
    while (la.size() != 0 || lb.size() != 0) begin
      if (la.size() != 0 && (lb.size() == 0 || $urandom_range(0, 1) == 1)) begin
        t = la.pop_front();
        queue_beat(smadd_pkg::OP_LOAD_A, t.row, t.col, t.value, no_gap);
      end else begin
        t = lb.pop_front();
        queue_beat(smadd_pkg::OP_LOAD_B, t.row, t.col, t.value, no_gap);
      end
    end
    // Full lists get a few more loads, which are dropped and flagged.
    if (disjoint) begin
      extra = $urandom_range(1, 3);
      repeat (extra)
        queue_beat($urandom_range(0, 1) ? smadd_pkg::OP_LOAD_B : smadd_pkg::OP_LOAD_A,
                   IDX_W'($urandom), IDX_W'($urandom), $urandom, no_gap);
    end
    queue_beat(smadd_pkg::OP_MERGE, IDX_W'($urandom), IDX_W'($urandom), $urandom, no_gap);
  endtask

  // Noise: arbitrary opcodes and unsorted positions, sometimes closed by a merge.
  task automatic queue_noise(bit no_gap);
    int n;
    n = $urandom_range(1, 8);
    repeat (n)
      queue_beat(OP_W'($urandom_range(0, 3)), IDX_W'($urandom), IDX_W'($urandom),
                 pick_value(1'b1), no_gap);
    if ($urandom_range(0, 1) == 1)
      queue_beat(smadd_pkg::OP_MERGE, IDX_W'($urandom), IDX_W'($urandom), $urandom, no_gap);
  endtask

  // Choose a new set of dimensions: extremes, matching, or mismatched.
  task automatic pick_dims();
    logic [DIM_W-1:0] ra;
    logic [DIM_W-1:0] ca;
    logic [DIM_W-1:0] rb;
    logic [DIM_W-1:0] cb;
    ra = DIM_W'($urandom_range(1, DIM_MAX));
    ca = DIM_W'($urandom_range(1, DIM_MAX));
    case ($urandom_range(0, 5))
      0, 5: begin
        ra = $urandom_range(0, 1) ? DIM_W'(DIM_MAX) : DIM_W'(1);
        ca = $urandom_range(0, 1) ? DIM_W'(DIM_MAX) : DIM_W'(1);
        rb = ra;
        cb = ca;
      end
      3: begin
        rb = ra;
        cb = ca;
        case ($urandom_range(0, 3))
          0: ra = DIM_W'((ra % DIM_MAX) + 1);
          1: ca = DIM_W'((ca % DIM_MAX) + 1);
          2: rb = DIM_W'((rb % DIM_MAX) + 1);
          default: cb = DIM_W'((cb % DIM_MAX) + 1);
        endcase
      end
      4: begin
        rb = DIM_W'($urandom_range(1, DIM_MAX));
        cb = DIM_W'($urandom_range(1, DIM_MAX));
      end
      default: begin
        rb = ra;
        cb = ca;
      end
    endcase
    write_cfg(smadd_pkg::REG_ROWS_A, ra);
    write_cfg(smadd_pkg::REG_COLS_A, ca);
    write_cfg(smadd_pkg::REG_ROWS_B, rb);
    write_cfg(smadd_pkg::REG_COLS_B, cb);
  endtask

  function automatic plan_row_t load_row(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                         logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] value);
    plan_row_t p;
    p.is_cfg           = 1'b0;
    p.cfg_index        = '0;
    p.cfg_data         = '0;
    p.beat.opcode      = op;
    p.beat.row         = row;
    p.beat.col         = col;
    p.beat.value       = value;
    p.beat.no_gap      = 1'b0;
    p.beat.has_typed   = 1'b0;
    p.beat.typed       = '0;
    return p;
  endfunction

  function automatic plan_row_t merge_row(bit typed_on, result_t want);
    plan_row_t p;
    p                = load_row(smadd_pkg::OP_MERGE, '0, '0, '0);
    p.beat.has_typed = typed_on;
    p.beat.typed     = want;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] index, logic [DIM_W-1:0] data);
    plan_row_t p;
    p           = load_row(OP_IGNORED, '0, '0, '0);
    p.is_cfg    = 1'b1;
    p.cfg_index = index;
    p.cfg_data  = data;
    return p;
  endfunction

  // Compare each result beat with the oldest awaited one.
  always @(posedge clk) begin
    if (!rst && result_strobe === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none awaited (row %0d col %0d value %0d)",
                                  out_row, out_col, out_value));
      end else begin
        oldest = awaited_results.pop_front();
        if (out_row !== oldest.row)
          report_mismatch($sformatf("out_row %0d, expected %0d", out_row, oldest.row));
        if (out_col !== oldest.col)
          report_mismatch($sformatf("out_col %0d, expected %0d", out_col, oldest.col));
        if (out_value !== oldest.value)
          report_mismatch($sformatf("out_value %0d, expected %0d", out_value, oldest.value));
        if (is_term !== oldest.is_term)
          report_mismatch($sformatf("is_term %0b, expected %0b", is_term, oldest.is_term));
        if (last !== oldest.last)
          report_mismatch($sformatf("last %0b, expected %0b", last, oldest.last));
        if (term_total !== oldest.total)
          report_mismatch($sformatf("term_total %0d, expected %0d", term_total, oldest.total));
        if (status !== oldest.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, oldest.status));
      end
    end
  end

  // Stop the run when no beat of any kind has been accepted for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || result_strobe === 1'b1 ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Main sequence: reset, directed plan, random runs, drain and verdict.
  initial begin
    int  seq_count;
    bit  did_full;
    bit  quiet;
    rst           = 1'b1;
    start         = 1'b0;
    opcode        = '0;
    term_row      = '0;
    term_col      = '0;
    term_value    = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    error_count   = 0;
    random_beats  = 0;
    fill_a        = 0;
    fill_b        = 0;
    overflow_flag = 1'b0;
    dim_rows_a    = DIM_W'(1);
    dim_cols_a    = DIM_W'(1);
    dim_rows_b    = DIM_W'(1);
    dim_cols_b    = DIM_W'(1);
    seq_count     = 0;
    did_full      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty merge right after reset.
    directed_plan.push_back(merge_row(1'b1,
        make_result('0, '0, '0, 1'b0, 1'b1, '0, smadd_pkg::ST_OK)));
    // Largest dimensions on both sides.
    directed_plan.push_back(cfg_row(smadd_pkg::REG_ROWS_A, DIM_W'(DIM_MAX)));
    directed_plan.push_back(cfg_row(smadd_pkg::REG_COLS_A, DIM_W'(DIM_MAX)));
    directed_plan.push_back(cfg_row(smadd_pkg::REG_ROWS_B, DIM_W'(DIM_MAX)));
    directed_plan.push_back(cfg_row(smadd_pkg::REG_COLS_B, DIM_W'(DIM_MAX)));
    // Zero sum kept, interleaving, and saturation at the top corner.
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_A, 6'd0, 6'd0, 32'sd0));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_A, 6'd0, 6'd5, -32'sd7));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_A, 6'd63, 6'd63, VAL_MAX));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_B, 6'd0, 6'd0, 32'sd0));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_B, 6'd0, 6'd3, 32'sd100));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_B, 6'd63, 6'd63, 32'sd1));
    directed_plan.push_back(merge_row(1'b0, '0));
    // Negative saturation.
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_A, 6'd10, 6'd20, VAL_MIN));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_B, 6'd10, 6'd20, -32'sd1));
    directed_plan.push_back(merge_row(1'b1,
        make_result(6'd10, 6'd20, VAL_MIN, 1'b1, 1'b1, 7'd1, smadd_pkg::ST_OK)));
    // The unused opcode changes nothing.
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_A, 6'd1, 6'd1, 32'sd5));
    directed_plan.push_back(load_row(OP_IGNORED, 6'd2, 6'd2, 32'sd9));
    directed_plan.push_back(merge_row(1'b1,
        make_result(6'd1, 6'd1, 32'sd5, 1'b1, 1'b1, 7'd1, smadd_pkg::ST_OK)));
    // Unsorted list A is taken as given, then list B's tail follows.
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_A, 6'd5, 6'd5, 32'sd1));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_A, 6'd2, 6'd2, 32'sd2));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_B, 6'd6, 6'd0, 32'sd3));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_B, 6'd1, 6'd1, 32'sd4));
    directed_plan.push_back(merge_row(1'b0, '0));
    // Size mismatch wins and yields a single status beat.
    directed_plan.push_back(cfg_row(smadd_pkg::REG_COLS_B, 7'd1));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_A, 6'd0, 6'd0, 32'sd1));
    directed_plan.push_back(load_row(smadd_pkg::OP_LOAD_B, 6'd0, 6'd0, 32'sd2));
    directed_plan.push_back(merge_row(1'b1,
        make_result('0, '0, '0, 1'b0, 1'b1, '0, smadd_pkg::ST_MISMATCH)));
    // Smallest dimensions on both sides.
    directed_plan.push_back(cfg_row(smadd_pkg::REG_ROWS_A, 7'd1));
    directed_plan.push_back(cfg_row(smadd_pkg::REG_COLS_A, 7'd1));
    directed_plan.push_back(cfg_row(smadd_pkg::REG_ROWS_B, 7'd1));

    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_cfg) begin
        drive_pending();
        settle();
        write_cfg(directed_plan[k].cfg_index, directed_plan[k].cfg_data);
      end else begin
        pending_beats.push_back(directed_plan[k].beat);
      end
    end
    drive_pending();
    settle();
    random_beats = 0;

    // Random runs, with a dimension change every few runs before the quiet part.
    while (random_beats < RANDOM_BEATS) begin
      quiet = (random_beats >= QUIET_AFTER);
      if (seq_count % 4 == 3 && !quiet) begin
        drive_pending();
        settle();
        pick_dims();
      end
      if (!did_full && random_beats >= 40) begin
        // Both lists full and disjoint: the longest merge, then a full pause.
        queue_merge_run(MAX_TERMS, MAX_TERMS, 1'b1, quiet);
        did_full = 1'b1;
        drive_pending();
        settle();
      end else if ($urandom_range(0, 7) == 0) begin
        queue_noise(quiet || $urandom_range(0, 2) == 0);
      end else begin
        queue_merge_run($urandom_range(0, 6), $urandom_range(0, 6), 1'b0,
                        quiet || $urandom_range(0, 2) == 0);
      end
      seq_count++;
    end
    drive_pending();

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
